// ===== hdl/zfr_pkg.sv =====
// Shared constants, types and codes of the zone frame reassembler.
// No dependencies; every other file of the block but zfr_checker imports this package.
`default_nettype none

package zfr_pkg;

   localparam int SEQ_SLOTS = 256;
   localparam int BLOCKS    = 32;

   localparam int SEQ_W      = $clog2(SEQ_SLOTS);
   localparam int BLK_W      = $clog2(BLOCKS);
   localparam int CNT_W      = $clog2(BLOCKS + 1);
   localparam int ZADDR_W    = SEQ_W + BLK_W;
   localparam int ZONE_DEPTH = SEQ_SLOTS * BLOCKS;
   localparam int DIST_W     = 16;
   localparam int ZONE_W     = 3 * DIST_W;
   localparam int ID_W       = 31;
   localparam int NZ_W       = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [NZ_W-1:0]   ZONES_MAX    = 7'd64;
   localparam logic [NZ_W-1:0]   MIN_LEN      = 7'd8;
   localparam logic [DIST_W-1:0] PAD_DIST     = 16'hFFFF;
   localparam logic [ID_W-1:0]   DFID_RESET   = '0;

   typedef enum logic {
      KIND_FRAME   = 1'b0,
      KIND_READOUT = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DATA_FRAME_ID = 1'b0,
      CSR_MAX_ZONES     = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      LANE_A = 2'd0,
      LANE_B = 2'd1,
      LANE_C = 2'd2
   } lane_type;

   // One row per sequence: distinct block count and per-block valid bits.
   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [BLOCKS-1:0] valid;
   } row_type;

   typedef struct packed {
      logic               row_rd;
      logic               row_wr;
      logic [SEQ_W-1:0]   row_addr;
      row_type            row_wdata;
      logic               clear_all;
      logic               zone_rd;
      logic               zone_wr;
      logic [ZADDR_W-1:0] zone_addr;
      logic [ZONE_W-1:0]  zone_wdata;
   } store_cmd_type;

endpackage

`default_nettype wire

// ===== hdl/zfr_ifs.sv =====
// Channel interfaces: request, response and register write channels.
// Depends on zfr_pkg.
`default_nettype none

interface zfr_req_if;
   import zfr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [31:0]              frame_id;
   logic [6:0]               frame_length;
   logic [7:0]               seq_number;
   logic [7:0]               block_index;
   logic signed [DIST_W-1:0] dist_a;
   logic signed [DIST_W-1:0] dist_b;
   logic signed [DIST_W-1:0] dist_c;

   modport source (output valid, kind, frame_id, frame_length, seq_number, block_index,
                   dist_a, dist_b, dist_c, input ready);
   modport sink   (input valid, kind, frame_id, frame_length, seq_number, block_index,
                   dist_a, dist_b, dist_c, output ready);
endinterface

interface zfr_rsp_if;
   import zfr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     status;
   logic [7:0]               seq_chosen;
   logic [5:0]               zone_index;
   logic signed [DIST_W-1:0] distance;
   logic [NZ_W-1:0]          zones_effective;
   logic [NZ_W-1:0]          zones_filled;
   logic                     last;

   modport source (output valid, status, seq_chosen, zone_index, distance,
                   zones_effective, zones_filled, last, input ready);
   modport sink   (input valid, status, seq_chosen, zone_index, distance,
                   zones_effective, zones_filled, last, output ready);
endinterface

interface zfr_csr_if;
   import zfr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ID_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/zfr_store.sv =====
// Sequence row memory (count + block valid bits) and zone distance memory.
// Depends on zfr_pkg. Both memories have registered reads.
`default_nettype none

module zfr_store (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire zfr_pkg::store_cmd_type cmd,
   output zfr_pkg::row_type           row_rdata,
   output logic [zfr_pkg::ZONE_W-1:0] zone_rdata
);
   import zfr_pkg::*;

   row_type              row_mem [SEQ_SLOTS];
   logic [ZONE_W-1:0]    zone_mem [ZONE_DEPTH];
   logic [SEQ_SLOTS-1:0] live_ff;
   logic                 row_live_ff;
   row_type              row_q_ff;
   logic [ZONE_W-1:0]    zone_q_ff;

   // row memory: a row whose live flag is clear reads as empty
   always_ff @(posedge clock) begin
      if (cmd.row_wr) begin
         row_mem[cmd.row_addr] <= cmd.row_wdata;
      end
      if (cmd.row_rd) begin
         row_q_ff <= row_mem[cmd.row_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff     <= '0;
         row_live_ff <= 1'b0;
      end else begin
         if (cmd.clear_all) begin
            live_ff <= '0;
         end else if (cmd.row_wr) begin
            live_ff[cmd.row_addr] <= 1'b1;
         end
         if (cmd.row_rd) begin
            row_live_ff <= live_ff[cmd.row_addr];
         end
      end
   end

   assign row_rdata = row_live_ff ? row_q_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.zone_wr) begin
         zone_mem[cmd.zone_addr] <= cmd.zone_wdata;
      end
      if (cmd.zone_rd) begin
         zone_q_ff <= zone_mem[cmd.zone_addr];
      end
   end

   assign zone_rdata = zone_q_ff;

endmodule

`default_nettype wire

// ===== hdl/zone_frame_reassembler_top.sv =====
// Zone frame reassembler: top level with control sequencer and registers.
// Depends on zfr_pkg, zfr_ifs (channel interfaces) and zfr_store.
//
// Usage:
//  - req_ch carries received frames (kind 0) and readout requests (kind 1).
//    One request is taken at a time; req_ch.ready is high when idle.
//  - A frame that matches the data ID, has length 8 or more and a block and
//    sequence in range is written by a row read, then a row and zone write.
//    Any other frame is dropped.
//  - A readout scans all SEQ_SLOTS rows of the row memory, then reads the
//    chosen sequence's zones twice: a first pass with a read and a check
//    per block of three works out the effective zone count, a second pass
//    puts out n results at one per cycle while the receiver does not stall,
//    with a zone read before each block. n is max_zones clamped to 1..64.
//    An empty store gives a single no-data result.
//  - rsp_ch has an output register: a stalled receiver holds the sequencer
//    at the next result; after the final result is loaded the block is idle
//    again and takes the next request while that result still waits.
//  - Reset: registers to defaults (data ID 0, max_zones 64) and every row
//    flag cleared at once; no clearing pass. The store is emptied the same
//    way at the end of each readout.
//  - csr_ch is always ready; write registers only while idle.
`default_nettype none

module zone_frame_reassembler_top (
   input  wire logic  clock,
   input  wire logic  reset,
   zfr_req_if.sink    req_ch,
   zfr_rsp_if.source  rsp_ch,
   zfr_csr_if.sink    csr_ch
);
   import zfr_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_FRM_WR   = 11'b00000000010,
      ST_SCAN     = 11'b00000000100,
      ST_SCAN_END = 11'b00000001000,
      ST_DECIDE   = 11'b00000010000,
      ST_NODATA   = 11'b00000100000,
      ST_EFF_RD   = 11'b00001000000,
      ST_EFF_CHK  = 11'b00010000000,
      ST_EMIT_RD  = 11'b00100000000,
      ST_EMIT_LD  = 11'b01000000000,
      ST_SPARE    = 11'b10000000000
   } state_type;

   localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_SLOTS - 1);

   // configuration registers
   logic [ID_W-1:0] dfid_ff;
   logic [NZ_W-1:0] max_zones_ff;

   // sequencer state
   state_type          state_ff, state_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [ZONE_W-1:0]  dist_ff, dist_in;
   logic [SEQ_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               pend_ff, pend_in;
   logic [SEQ_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [SEQ_W-1:0]   best_ff, best_in;
   logic [CNT_W-1:0]   best_cnt_ff, best_cnt_in;
   logic [BLOCKS-1:0]  best_valid_ff, best_valid_in;
   logic [NZ_W-1:0]    n_ff, n_in;
   logic [NZ_W-1:0]    eff_ff, eff_in;
   logic [NZ_W-1:0]    zbase_ff, zbase_in;
   logic [5:0]         zi_ff, zi_in;
   lane_type           lane_ff, lane_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic               out_status_ff, out_status_in;
   logic [7:0]         out_seq_ff, out_seq_in;
   logic [5:0]         out_zi_ff, out_zi_in;
   logic [DIST_W-1:0]  out_dist_ff, out_dist_in;
   logic [NZ_W-1:0]    out_eff_ff, out_eff_in;
   logic [NZ_W-1:0]    out_filled_ff, out_filled_in;
   logic               out_last_ff, out_last_in;

   store_cmd_type      cmd;
   row_type            row_rdata;
   logic [ZONE_W-1:0]  zone_rdata;

   logic               req_fire;
   logic               frame_keep;
   logic               out_free;
   logic [NZ_W-1:0]    eff_final;
   logic [DIST_W-1:0]  lane_dist;
   logic               emit_last;

   zfr_store u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .row_rdata  (row_rdata),
      .zone_rdata (zone_rdata)
   );

   // --- configuration port ---
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dfid_ff      <= DFID_RESET;
         max_zones_ff <= ZONES_MAX;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_DATA_FRAME_ID: dfid_ff      <= csr_ch.data;
            CSR_MAX_ZONES:     max_zones_ff <= csr_ch.data[NZ_W-1:0];
            default: ;
         endcase
      end
   end

   // --- request side ---
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // bit 31 of the raw ID is ignored
   assign frame_keep = (req_ch.frame_id[ID_W-1:0] == dfid_ff) &&
                       (req_ch.frame_length >= MIN_LEN) &&
                       ({1'b0, req_ch.block_index} < 9'(BLOCKS)) &&
                       ({1'b0, req_ch.seq_number} < 9'(SEQ_SLOTS));

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign eff_final = (eff_ff == '0) ? n_ff : eff_ff;
   assign emit_last = ((NZ_W'(zi_ff) + NZ_W'(1)) == n_ff);

   always_comb begin
      case (lane_ff)
         LANE_A:  lane_dist = zone_rdata[0*DIST_W +: DIST_W];
         LANE_B:  lane_dist = zone_rdata[1*DIST_W +: DIST_W];
         LANE_C:  lane_dist = zone_rdata[2*DIST_W +: DIST_W];
         default: lane_dist = PAD_DIST;
      endcase
   end

   // --- sequencer ---
   always_comb begin
      logic [NZ_W-1:0] z;

      state_in      = state_ff;
      seq_in        = seq_ff;
      blk_in        = blk_ff;
      dist_in       = dist_ff;
      scan_idx_in   = scan_idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      best_in       = best_ff;
      best_cnt_in   = best_cnt_ff;
      best_valid_in = best_valid_ff;
      n_in          = n_ff;
      eff_in        = eff_ff;
      zbase_in      = zbase_ff;
      zi_in         = zi_ff;
      lane_in       = lane_ff;

      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_status_in = out_status_ff;
      out_seq_in    = out_seq_ff;
      out_zi_in     = out_zi_ff;
      out_dist_in   = out_dist_ff;
      out_eff_in    = out_eff_ff;
      out_filled_in = out_filled_ff;
      out_last_in   = out_last_ff;

      cmd           = '0;
      z             = '0;

      // scan compare, in the cycle after the row read
      if (pend_ff && (row_rdata.count != '0) &&
          ((row_rdata.count > best_cnt_ff) ||
           ((row_rdata.count == best_cnt_ff) && row_rdata.valid[0]))) begin
         best_in       = pend_idx_ff;
         best_cnt_in   = row_rdata.count;
         best_valid_in = row_rdata.valid;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (kind_type'(req_ch.kind) == KIND_READOUT) begin
                  scan_idx_in = '0;
                  pend_in     = 1'b0;
                  best_in     = '0;
                  best_cnt_in = '0;
                  state_in    = ST_SCAN;
               end else if (frame_keep) begin
                  cmd.row_rd   = 1'b1;
                  cmd.row_addr = req_ch.seq_number[SEQ_W-1:0];
                  seq_in       = req_ch.seq_number[SEQ_W-1:0];
                  blk_in       = req_ch.block_index[BLK_W-1:0];
                  dist_in      = {req_ch.dist_c, req_ch.dist_b, req_ch.dist_a};
                  state_in     = ST_FRM_WR;
               end
            end
         end
         ST_FRM_WR: begin
            cmd.row_wr          = 1'b1;
            cmd.row_addr        = seq_ff;
            cmd.row_wdata.valid = row_rdata.valid | (BLOCKS'(1) << blk_ff);
            cmd.row_wdata.count = row_rdata.valid[blk_ff] ? row_rdata.count
                                                          : row_rdata.count + CNT_W'(1);
            cmd.zone_wr         = 1'b1;
            cmd.zone_addr       = {seq_ff, blk_ff};
            cmd.zone_wdata      = dist_ff;
            state_in            = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.row_rd   = 1'b1;
            cmd.row_addr = scan_idx_ff;
            pend_in      = 1'b1;
            pend_idx_in  = scan_idx_ff;
            scan_idx_in  = scan_idx_ff + SEQ_W'(1);
            if (scan_idx_ff == SEQ_LAST) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            pend_in  = 1'b0;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (best_cnt_ff == '0) begin
               state_in = ST_NODATA;
            end else begin
               if (max_zones_ff == '0) begin
                  n_in = NZ_W'(1);
               end else if (max_zones_ff > ZONES_MAX) begin
                  n_in = ZONES_MAX;
               end else begin
                  n_in = max_zones_ff;
               end
               eff_in   = '0;
               zbase_in = '0;
               blk_in   = '0;
               state_in = ST_EFF_RD;
            end
         end
         ST_NODATA: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = 1'b0;
               out_seq_in    = '0;
               out_zi_in     = '0;
               out_dist_in   = '0;
               out_eff_in    = '0;
               out_filled_in = '0;
               out_last_in   = 1'b1;
               cmd.clear_all = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EFF_RD: begin
            cmd.zone_rd   = 1'b1;
            cmd.zone_addr = {best_ff, blk_ff};
            state_in      = ST_EFF_CHK;
         end
         ST_EFF_CHK: begin
            // zones 0..63 lie in blocks 0..21, always below BLOCKS
            for (int l = 0; l < 3; l++) begin
               z = zbase_ff + NZ_W'(l);
               if ((z < n_ff) && best_valid_ff[blk_ff] &&
                   (zone_rdata[l*DIST_W +: DIST_W] != PAD_DIST)) begin
                  eff_in = z + NZ_W'(1);
               end
            end
            zbase_in = zbase_ff + NZ_W'(3);
            blk_in   = blk_ff + BLK_W'(1);
            if ((zbase_ff + NZ_W'(3)) >= n_ff) begin
               blk_in   = '0;
               zi_in    = '0;
               lane_in  = LANE_A;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_EFF_RD;
            end
         end
         ST_EMIT_RD: begin
            cmd.zone_rd   = 1'b1;
            cmd.zone_addr = {best_ff, blk_ff};
            state_in      = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = 1'b1;
               out_seq_in    = 8'(best_ff);
               out_zi_in     = zi_ff;
               out_dist_in   = best_valid_ff[blk_ff] ? lane_dist : PAD_DIST;
               out_eff_in    = eff_final;
               out_filled_in = n_ff;
               out_last_in   = emit_last;
               if (emit_last) begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  zi_in = zi_ff + 6'd1;
                  if (lane_ff == LANE_C) begin
                     lane_in  = LANE_A;
                     blk_in   = blk_ff + BLK_W'(1);
                     state_in = ST_EMIT_RD;
                  end else begin
                     lane_in = lane_type'(lane_ff + 2'd1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff        <= seq_in;
      blk_ff        <= blk_in;
      dist_ff       <= dist_in;
      scan_idx_ff   <= scan_idx_in;
      pend_idx_ff   <= pend_idx_in;
      best_ff       <= best_in;
      best_cnt_ff   <= best_cnt_in;
      best_valid_ff <= best_valid_in;
      n_ff          <= n_in;
      eff_ff        <= eff_in;
      zbase_ff      <= zbase_in;
      zi_ff         <= zi_in;
      lane_ff       <= lane_in;
      out_status_ff <= out_status_in;
      out_seq_ff    <= out_seq_in;
      out_zi_ff     <= out_zi_in;
      out_dist_ff   <= out_dist_in;
      out_eff_ff    <= out_eff_in;
      out_filled_ff <= out_filled_in;
      out_last_ff   <= out_last_in;
   end

   // --- response side ---
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.status          = out_status_ff;
   assign rsp_ch.seq_chosen      = out_seq_ff;
   assign rsp_ch.zone_index      = out_zi_ff;
   assign rsp_ch.distance        = out_dist_ff;
   assign rsp_ch.zones_effective = out_eff_ff;
   assign rsp_ch.zones_filled    = out_filled_ff;
   assign rsp_ch.last            = out_last_ff;

endmodule

`default_nettype wire

// ===== hdl/zfr_checker.sv =====
// Port-level checks on the response channel of the top level, with bind.
// Depends on zone_frame_reassembler_top and the channel interfaces.
`default_nettype none

module zfr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_status,
   input wire logic       rsp_last,
   input wire logic [5:0] rsp_zone_index,
   input wire logic [6:0] rsp_zones_effective,
   input wire logic [6:0] rsp_zones_filled
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_nodata: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_last && (rsp_zones_filled == 7'd0))
      else $error("no-data response malformed");

   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         ({1'b0, rsp_zone_index} < rsp_zones_filled) &&
         (rsp_last == (({1'b0, rsp_zone_index} + 7'd1) == rsp_zones_filled)))
      else $error("zone index or last flag out of step with zone count");

   a_eff: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         (rsp_zones_effective != 7'd0) && (rsp_zones_effective <= rsp_zones_filled))
      else $error("effective zone count out of range");

endmodule

bind zone_frame_reassembler_top zfr_checker u_zfr_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_status          (rsp_ch.status),
   .rsp_last            (rsp_ch.last),
   .rsp_zone_index      (rsp_ch.zone_index),
   .rsp_zones_effective (rsp_ch.zones_effective),
   .rsp_zones_filled    (rsp_ch.zones_filled)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for zone_frame_reassembler_top: drives frames and readouts,
// predicts every zone result and checks it. Needs zfr_pkg, zfr_ifs and the RTL.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import zfr_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 41;

   // One request on the input channel, and one zone result on the output.
   typedef struct {
      kind_type                 kind;
      logic [31:0]              frame_id;
      logic [6:0]               frame_length;
      logic [7:0]               seq_number;
      logic [7:0]               block_index;
      logic signed [DIST_W-1:0] dist_a;
      logic signed [DIST_W-1:0] dist_b;
      logic signed [DIST_W-1:0] dist_c;
   } zone_req_type;

   typedef struct {
      logic                     status;
      logic [7:0]               seq_chosen;
      logic [5:0]               zone_index;
      logic signed [DIST_W-1:0] distance;
      logic [NZ_W-1:0]          zones_effective;
      logic [NZ_W-1:0]          zones_filled;
      logic                     is_last;
   } zone_result_type;

   logic clock;
   logic reset;

   zfr_req_if req_ch ();
   zfr_rsp_if rsp_ch ();
   zfr_csr_if csr_ch ();

   zone_frame_reassembler_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // ---------------------------------------------------------------------
   // Shadow of the block: registers and the frame store.
   // ---------------------------------------------------------------------
   logic [ID_W-1:0]   frame_id_cfg;
   logic [NZ_W-1:0]   zones_cfg;
   bit                blk_seen  [SEQ_SLOTS][BLOCKS];
   int unsigned       blk_total [SEQ_SLOTS];
   logic [DIST_W-1:0] zone_mem  [SEQ_SLOTS][BLOCKS][3];

   zone_req_type    pending_reqs[$];     // requests still to be driven
   zone_result_type expected_zones[$];   // zone results owed by the block

   zone_req_type req_held;            // request currently on the channel
   int        req_gap;                // idle cycles left before the next request
   int        rsp_stall;              // cycles left with rsp ready held low
   int        req_gap_pct;
   int        rsp_stall_pct;
   int        faults;
   int        cycles;

   task automatic wipe_store();
      int s, b;
      for (s = 0; s < SEQ_SLOTS; s++) begin
         blk_total[s] = 0;
         for (b = 0; b < BLOCKS; b++)
            blk_seen[s][b] = 1'b0;
      end
   endtask

   // Applies one accepted request to the shadow store; a readout queues the
   // zone results it must produce.
   task automatic reassemble(input zone_req_type rq);
      int unsigned       best, best_cnt, n, eff, b;
      int                s, i;
      logic [DIST_W-1:0] d [64];
      zone_result_type   r;
      if (rq.kind == KIND_FRAME) begin
         if (rq.frame_id[ID_W-1:0] == frame_id_cfg && rq.frame_length >= MIN_LEN &&
             rq.block_index < BLOCKS && rq.seq_number < SEQ_SLOTS) begin
            if (!blk_seen[rq.seq_number][rq.block_index]) begin
               blk_seen[rq.seq_number][rq.block_index] = 1'b1;
               blk_total[rq.seq_number]++;
            end
            zone_mem[rq.seq_number][rq.block_index][0] = rq.dist_a;
            zone_mem[rq.seq_number][rq.block_index][1] = rq.dist_b;
            zone_mem[rq.seq_number][rq.block_index][2] = rq.dist_c;
         end
         return;
      end
      // Most distinct blocks wins; a tie goes to the later sequence only if
      // it holds block 0.
      best     = 0;
      best_cnt = 0;
      for (s = 0; s < SEQ_SLOTS; s++)
         if (blk_total[s] != 0 && (blk_total[s] > best_cnt ||
             (blk_total[s] == best_cnt && blk_seen[s][0]))) begin
            best_cnt = blk_total[s];
            best     = s;
         end
      if (best_cnt == 0) begin
         r = '{default: 0};
         r.is_last = 1'b1;
         expected_zones.push_back(r);
         return;
      end
      n = zones_cfg;
      if (n < 1)
         n = 1;
      if (n > ZONES_MAX)
         n = ZONES_MAX;
      eff = 0;
      for (i = 0; i < n; i++) begin
         b = i / 3;
         if (b < BLOCKS && blk_seen[best][b])
            d[i] = zone_mem[best][b][i % 3];
         else
            d[i] = PAD_DIST;
         if (d[i] != PAD_DIST)
            eff = i + 1;
      end
      if (eff == 0)
         eff = n;
      for (i = 0; i < n; i++) begin
         r.status          = 1'b1;
         r.seq_chosen      = 8'(best);
         r.zone_index      = 6'(i);
         r.distance        = d[i];
         r.zones_effective = NZ_W'(eff);
         r.zones_filled    = NZ_W'(n);
         r.is_last         = (i + 1 == n);
         expected_zones.push_back(r);
      end
      wipe_store();
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [DIST_W-1:0] rand_dist();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick < 2)
         return PAD_DIST;             // stored -1 reads as padding
      if (pick == 2)
         return 16'h8000;
      if (pick == 3)
         return 16'h7FFF;
      return 16'($urandom);
   endfunction

   function automatic zone_req_type mk_frame(logic [31:0] id, int len, int seq, int blk,
                                             logic [DIST_W-1:0] a, logic [DIST_W-1:0] b,
                                             logic [DIST_W-1:0] c);
      zone_req_type rq;
      rq.kind         = KIND_FRAME;
      rq.frame_id     = id;
      rq.frame_length = 7'(len);
      rq.seq_number   = 8'(seq);
      rq.block_index  = 8'(blk);
      rq.dist_a       = a;
      rq.dist_b       = b;
      rq.dist_c       = c;
      return rq;
   endfunction

   // Readout request: the payload fields carry noise and must be ignored.
   function automatic zone_req_type mk_readout();
      zone_req_type rq;
      rq      = mk_frame($urandom, $urandom_range(0, 64), $urandom_range(0, 255),
                         $urandom_range(0, 255), rand_dist(), rand_dist(), rand_dist());
      rq.kind = KIND_READOUT;
      return rq;
   endfunction

   // Random mix for one phase: mostly well-formed frames over a small pool
   // of sequences so that readouts find real maps, plus broken frames,
   // pure noise and the odd readout.
   task automatic queue_phase(input int items);
      int          k, blk;
      int unsigned pick;
      int          pool [3];
      pool[0] = ($urandom_range(0, 3) == 0) ? 0 : (($urandom_range(0, 3) == 0) ? 255 :
                $urandom_range(0, 255));
      pool[1] = $urandom_range(0, 255);
      pool[2] = $urandom_range(0, 255);
      for (k = 0; k < items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            pending_reqs.push_back(mk_readout());
         else if (pick < 80) begin
            blk = ($urandom_range(0, 9) == 0) ? $urandom_range(22, BLOCKS - 1) :
                  $urandom_range(0, 21);
            pending_reqs.push_back(mk_frame({1'($urandom), frame_id_cfg},
                                            $urandom_range(MIN_LEN, 64),
                                            pool[$urandom_range(0, 2)], blk,
                                            rand_dist(), rand_dist(), rand_dist()));
         end else if (pick < 90) begin
            // matching ID but either too short or a block beyond the store
            if ($urandom_range(0, 1))
               pending_reqs.push_back(mk_frame({1'($urandom), frame_id_cfg},
                                               $urandom_range(0, MIN_LEN - 1),
                                               pool[0], $urandom_range(0, 21),
                                               rand_dist(), rand_dist(), rand_dist()));
            else
               pending_reqs.push_back(mk_frame({1'($urandom), frame_id_cfg},
                                               $urandom_range(MIN_LEN, 64), pool[1],
                                               $urandom_range(BLOCKS, 255),
                                               rand_dist(), rand_dist(), rand_dist()));
         end else
            pending_reqs.push_back(mk_frame($urandom, $urandom_range(0, 64),
                                            $urandom_range(0, 255), $urandom_range(0, 255),
                                            rand_dist(), rand_dist(), rand_dist()));
      end
      pending_reqs.push_back(mk_readout());
   endtask

   // Register write; the shadow copy follows once the write is taken.
   task automatic write_reg(input csr_index_type idx, input logic [ID_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_DATA_FRAME_ID)
         frame_id_cfg = val;
      else
         zones_cfg = val[NZ_W-1:0];
   endtask

   // Waits until every request is taken and every result has come back,
   // then lets a frame write still in flight finish.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_ch.valid || expected_zones.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Request driver: one request from the queue at a time, held until
   // taken, with random idle bursts after some of them.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            reassemble(req_held);
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0 || pending_reqs.size() == 0) begin
               if (req_gap > 0)
                  req_gap--;
               req_ch.valid <= 1'b0;
            end else begin
               req_held = pending_reqs.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.kind         <= req_held.kind;
               req_ch.frame_id     <= req_held.frame_id;
               req_ch.frame_length <= req_held.frame_length;
               req_ch.seq_number   <= req_held.seq_number;
               req_ch.block_index  <= req_held.block_index;
               req_ch.dist_a       <= req_held.dist_a;
               req_ch.dist_b       <= req_held.dist_b;
               req_ch.dist_c       <= req_held.dist_c;
               if ($urandom_range(0, 99) < req_gap_pct)
                  req_gap = $urandom_range(1, 7);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: checks each taken result against the oldest one owed,
   // and stalls the output in random bursts.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      zone_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_zones.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("%0t: unexpected result st=%0b seq=%0d zone=%0d dist=%0d",
                           $realtime, rsp_ch.status, rsp_ch.seq_chosen,
                           rsp_ch.zone_index, rsp_ch.distance);
            end else begin
               want = expected_zones.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.seq_chosen !== want.seq_chosen ||
                   rsp_ch.zone_index !== want.zone_index ||
                   rsp_ch.distance !== want.distance ||
                   rsp_ch.zones_effective !== want.zones_effective ||
                   rsp_ch.zones_filled !== want.zones_filled ||
                   rsp_ch.last !== want.is_last) begin
                  faults++;
                  if (faults <= 10)
                     $display({"%0t: mismatch exp st=%0b seq=%0d zone=%0d dist=%0d eff=%0d ",
                               "fill=%0d last=%0b / got st=%0b seq=%0d zone=%0d dist=%0d ",
                               "eff=%0d fill=%0d last=%0b"}, $realtime,
                              want.status, want.seq_chosen, want.zone_index, want.distance,
                              want.zones_effective, want.zones_filled, want.is_last,
                              rsp_ch.status, rsp_ch.seq_chosen, rsp_ch.zone_index,
                              rsp_ch.distance, rsp_ch.zones_effective,
                              rsp_ch.zones_filled, rsp_ch.last);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < rsp_stall_pct)
               rsp_stall = $urandom_range(1, 7);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[zone_frame_reassembler_top] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [ID_W-1:0] ids   [PHASES];
      logic [ID_W-1:0] zones [PHASES];
      int              p;

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.kind         = KIND_FRAME;
      req_ch.frame_id     = '0;
      req_ch.frame_length = '0;
      req_ch.seq_number   = '0;
      req_ch.block_index  = '0;
      req_ch.dist_a       = '0;
      req_ch.dist_b       = '0;
      req_ch.dist_c       = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_DATA_FRAME_ID;
      csr_ch.data         = '0;
      frame_id_cfg        = DFID_RESET;
      zones_cfg           = ZONES_MAX;
      req_gap_pct         = 20;
      rsp_stall_pct       = 20;
      faults              = 0;
      cycles              = 0;
      wipe_store();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, on reset settings (data ID 0, 64 zones).
      pending_reqs.push_back(mk_readout());                              // nothing stored
      pending_reqs.push_back(mk_frame(32'h8000_0000, 8, 0, 0,            // ID bit 31 ignored
                                      16'h7FFF, 16'h8000, PAD_DIST));
      pending_reqs.push_back(mk_frame(0, 7, 0, 1, 1, 1, 1));             // too short
      pending_reqs.push_back(mk_frame(0, 64, 0, 1, 1, 2, 3));            // length 64
      pending_reqs.push_back(mk_frame(1, 8, 0, 2, 4, 5, 6));             // foreign ID
      pending_reqs.push_back(mk_frame(0, 8, 0, BLOCKS, 7, 7, 7));        // block out of range
      pending_reqs.push_back(mk_frame(0, 8, 0, 255, 7, 7, 7));
      pending_reqs.push_back(mk_frame(0, 8, 0, BLOCKS - 1, 9, 9, 9));    // beyond readout
      pending_reqs.push_back(mk_frame(0, 8, 0, 21, 100, 200, 300));      // straddles zone 63
      pending_reqs.push_back(mk_frame(0, 8, 0, 0, 16'h8000, 0, 16'h7FFF)); // overwrite
      pending_reqs.push_back(mk_frame(0, 0, 0, 3, 1, 1, 1));             // empty frame
      pending_reqs.push_back(mk_readout());
      // tie on block count: only a later sequence holding block 0 takes over
      pending_reqs.push_back(mk_frame(0, 8, 3, 4, 11, 12, 13));
      pending_reqs.push_back(mk_frame(0, 8, 3, 5, 14, 15, 16));
      pending_reqs.push_back(mk_frame(0, 8, 5, 0, PAD_DIST, PAD_DIST, PAD_DIST));
      pending_reqs.push_back(mk_frame(0, 8, 5, 2, 7, 8, 9));
      pending_reqs.push_back(mk_frame(0, 8, 255, 6, 21, 22, 23));
      pending_reqs.push_back(mk_frame(0, 8, 255, 7, 24, 25, 26));
      pending_reqs.push_back(mk_readout());
      // every stored distance is padding: full count as effective
      pending_reqs.push_back(mk_frame(0, 8, 9, 0, PAD_DIST, PAD_DIST, PAD_DIST));
      pending_reqs.push_back(mk_readout());

      // Settings per phase; zone counts of 0 and 127 are clamped to 1 and 64.
      ids[0] = 31'h7FFF_FFFF; zones[0] = 1;
      ids[1] = 31'($urandom);  zones[1] = 0;
      ids[2] = 31'($urandom);  zones[2] = 127;
      ids[3] = 31'($urandom);  zones[3] = $urandom_range(2, 63);
      ids[4] = '0;             zones[4] = ZONES_MAX;
      ids[5] = 31'($urandom);  zones[5] = $urandom_range(1, 64);

      for (p = 0; p < PHASES; p++) begin
         wait_quiet();
         write_reg(CSR_DATA_FRAME_ID, ids[p]);
         write_reg(CSR_MAX_ZONES, zones[p]);
         @(negedge clock);
         // last phase runs flat out on both sides
         if (p == PHASES - 1) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = $urandom_range(0, 2) * 20;
            rsp_stall_pct = $urandom_range(0, 2) * 20;
         end
         queue_phase(PHASE_ITEMS);
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      if (expected_zones.size() != 0)
         faults++;
      if (faults == 0)
         $display("[zone_frame_reassembler_top] OK");
      else
         $display("[zone_frame_reassembler_top] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/zfr_pkg.sv
hdl/zfr_ifs.sv
hdl/zfr_store.sv
hdl/zone_frame_reassembler_top.sv
hdl/zfr_checker.sv
tb/tb_top.sv
